>>> design/quic_cid_socket_steering_unit_assert.svh
// Assertion macros for the QUIC CID socket steering unit.
`ifndef QUIC_CID_SOCKET_STEERING_UNIT_ASSERT_SVH
`define QUIC_CID_SOCKET_STEERING_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define QCSS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qcss assertion failed");
// Condition that must never be seen.
`define QCSS_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("qcss forbidden condition seen");
`else
`define QCSS_ASSERT(lbl, prop)
`define QCSS_NEVER(lbl, cond)
`endif
`endif

>>> design/qcss_pkg.sv
// Shared types and constants of the QUIC CID socket steering unit.
package qcss_pkg;
	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_ROUTE_SLOTS   = 64;
	localparam int DEF_CID_BYTES     = 20;

	localparam int MAX_CID     = 20;
	localparam int UDP_HDR_LEN = 8;
	localparam int LONG_EXTRA  = 5;
	localparam int POS_LIMIT   = 34;
	localparam int FORM_BIT    = 7;
	localparam int HASH_W      = 32;
	localparam int SLOT_W      = 7;
	localparam int POS_W       = 6;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 1;

	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_TABLE = 1'b1;

	localparam logic [1:0] SEL_HEAD   = 2'd0;
	localparam logic [1:0] SEL_MIDDLE = 2'd1;
	localparam logic [1:0] SEL_TAIL   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_PRESENT = 1'b1;

	localparam logic [1:0] V_DROP   = 2'd0;
	localparam logic [1:0] V_WORKER = 2'd1;
	localparam logic [1:0] V_LISTEN = 2'd2;
endpackage

>>> design/qcss_in_if.sv
// Input channel: datagram bytes and connection table writes.
interface qcss_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [31:0] flow_hash;
	logic [7:0]  table_index;
	logic [1:0]  table_word_select;
	logic [63:0] table_word;
	logic        table_valid;
	logic [15:0] table_worker;

	modport source(output valid, kind, data_byte, last_byte, flow_hash, table_index,
		table_word_select, table_word, table_valid, table_worker, input ready);
	modport sink(input valid, kind, data_byte, last_byte, flow_hash, table_index,
		table_word_select, table_word, table_valid, table_worker, output ready);
endinterface

>>> design/qcss_out_if.sv
// Output channel: one steering verdict per datagram.
interface qcss_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [15:0] target;

	modport source(output valid, verdict, target, input ready);
	modport sink(input valid, verdict, target, output ready);
endinterface

>>> design/quic_cid_socket_steering_unit.sv
// Sequence: a byte or table write item is taken while idle; a last byte then starts a decision:
// a table scan that reads and then compares each entry (one memory read port) and, for a long
// header with no hit, a bit-serial modulo of the flow hash and a slot scan for placement.
// Input is not ready while a decision runs; a verdict may wait in the output register.
// Reset (arst_n, async, active low) clears control state and starts a clearing pass over
// the valid marks of all table entries, during which no item is taken.
`include "quic_cid_socket_steering_unit_assert.svh"
module quic_cid_socket_steering_unit #(
	parameter int TABLE_ENTRIES = qcss_pkg::DEF_TABLE_ENTRIES,
	parameter int ROUTE_SLOTS   = qcss_pkg::DEF_ROUTE_SLOTS,
	parameter int CID_BYTES     = qcss_pkg::DEF_CID_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	qcss_in_if.sink                             in_ch,
	qcss_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [qcss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qcss_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import qcss_pkg::*;

	localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = TW + 1;
	localparam int TAIL_W = 32 + 1 + 16;

	// One-hot sequencer.
	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_DECIDE = 8'b0000_0100,
		ST_RD     = 8'b0000_1000,
		ST_CMP    = 8'b0001_0000,
		ST_DIV    = 8'b0010_0000,
		ST_PLACE  = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SLOT_W-1:0] slot_count_q;
	logic [63:0]       listen_q;

	// Per-datagram parse state.
	logic [POS_W-1:0] pos_q;
	logic             long_q;
	logic             dlm_q;
	logic [7:0]       cap_q [MAX_CID];
	logic [HASH_W-1:0] hash_q;

	// Connection table: three memories, valid and worker kept with the tail.
	logic [63:0]       mem_head   [TABLE_ENTRIES];
	logic [63:0]       mem_middle [TABLE_ENTRIES];
	logic [TAIL_W-1:0] mem_tail   [TABLE_ENTRIES];
	logic [63:0]       rd_head_q;
	logic [63:0]       rd_middle_q;
	logic [TAIL_W-1:0] rd_tail_q;

	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     clr_q;

	// Modulo and slot search.
	logic [SLOT_W-1:0] rem_q;
	logic [4:0]        div_cnt_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] idx_q;

	logic [1:0]  verdict_q;
	logic [15:0] target_q;

	logic        out_valid_q;
	logic [1:0]  out_verdict_q;
	logic [15:0] out_target_q;

	logic in_acc;
	logic byte_acc;
	logic tbl_acc;
	logic idx_ok;
	logic [TW+7:0] idx_wide;
	logic [TW-1:0] wr_addr;
	logic [TW-1:0] rd_addr;
	logic          tail_we;
	logic [TW-1:0] tail_addr;
	logic [TAIL_W-1:0] tail_wdata;

	logic [POS_W-1:0] start_pos;
	logic [POS_W-1:0] cap_off;
	logic             cap_en;
	logic [POS_W-1:0] need_pos;
	logic             place_ok;
	logic             cid_hit;
	logic [159:0]     tbl_cid;
	logic [SLOT_W-1:0] div_try;
	logic              out_load;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc   = in_ch.valid && in_ch.ready;
	assign byte_acc = in_acc && (in_ch.kind == KIND_BYTE);
	assign tbl_acc  = in_acc && (in_ch.kind == KIND_TABLE);

	assign idx_ok   = 32'(in_ch.table_index) < 32'(TABLE_ENTRIES);
	assign idx_wide = {{TW{1'b0}}, in_ch.table_index};
	assign wr_addr  = idx_wide[TW-1:0];
	assign rd_addr  = scan_q[TW-1:0];

	// Tail memory port is shared by the clearing pass and tail writes.
	always_comb begin
		tail_we    = 1'b0;
		tail_addr  = wr_addr;
		tail_wdata = {in_ch.table_word[63:32], in_ch.table_valid, in_ch.table_worker};
		if (state_q == ST_CLEAR) begin
			tail_we    = 1'b1;
			tail_addr  = clr_q[TW-1:0];
			tail_wdata = '0;
		end else if (tbl_acc && idx_ok && in_ch.table_word_select == SEL_TAIL) begin
			tail_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_acc && idx_ok && in_ch.table_word_select == SEL_HEAD)
			mem_head[wr_addr] <= in_ch.table_word;
		rd_head_q <= mem_head[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (tbl_acc && idx_ok && in_ch.table_word_select == SEL_MIDDLE)
			mem_middle[wr_addr] <= in_ch.table_word;
		rd_middle_q <= mem_middle[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (tail_we)
			mem_tail[tail_addr] <= tail_wdata;
		rd_tail_q <= mem_tail[rd_addr];
	end

	// Byte parse: DCID starts after the first QUIC byte, or after the long header.
	assign start_pos = long_q ? POS_W'(UDP_HDR_LEN + 1 + LONG_EXTRA) : POS_W'(UDP_HDR_LEN + 1);
	assign cap_off   = pos_q - start_pos;
	assign cap_en    = (pos_q > POS_W'(UDP_HDR_LEN)) && (pos_q >= start_pos)
		&& (32'(cap_off) < 32'(CID_BYTES));
	assign need_pos  = start_pos + POS_W'(CID_BYTES);
	assign place_ok  = (slot_count_q != '0) && (32'(slot_count_q) <= 32'(ROUTE_SLOTS));

	// CID compare over the first CID_BYTES bytes; valid mark sits above the worker.
	assign tbl_cid = {rd_head_q, rd_middle_q, rd_tail_q[TAIL_W-1 -: 32]};
	always_comb begin
		cid_hit = rd_tail_q[16];
		for (int i = 0; i < MAX_CID; i++) begin
			if (i < CID_BYTES && tbl_cid[159 - 8*i -: 8] != cap_q[i])
				cid_hit = 1'b0;
		end
	end

	// One step of restoring division; remainder stays below the slot count.
	always_comb begin
		div_try = {rem_q[SLOT_W-2:0], hash_q[HASH_W-1]};
		if (div_try >= slot_count_q)
			div_try = div_try - slot_count_q;
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			listen_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLOT_COUNT:   slot_count_q <= cfg_data[SLOT_W-1:0];
				CFG_SLOT_PRESENT: listen_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			pos_q     <= '0;
			long_q    <= 1'b0;
			dlm_q     <= 1'b0;
			for (int i = 0; i < MAX_CID; i++) cap_q[i] <= '0;
			scan_q    <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
			slot_q    <= '0;
			idx_q     <= '0;
			verdict_q <= V_DROP;
			target_q  <= '0;
			hash_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(TABLE_ENTRIES - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (byte_acc) begin
						if (32'(pos_q) < 32'(POS_LIMIT)) begin
							if (32'(pos_q) == 32'(UDP_HDR_LEN))
								long_q <= in_ch.data_byte[FORM_BIT];
							if (32'(pos_q) == 32'(UDP_HDR_LEN + LONG_EXTRA))
								dlm_q <= (in_ch.data_byte == 8'(CID_BYTES));
							if (cap_en)
								cap_q[cap_off[4:0]] <= in_ch.data_byte;
							pos_q <= pos_q + 1'b1;
						end
						if (in_ch.last_byte) begin
							hash_q  <= in_ch.flow_hash;
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					verdict_q <= V_DROP;
					target_q  <= '0;
					scan_q    <= '0;
					rem_q     <= '0;
					div_cnt_q <= '0;
					if (pos_q < POS_W'(UDP_HDR_LEN + 1)) begin
						state_q <= ST_DONE;
					end else if (long_q && pos_q < POS_W'(UDP_HDR_LEN + 1 + LONG_EXTRA)) begin
						state_q <= ST_DONE;
					end else if (long_q && !dlm_q) begin
						state_q <= place_ok ? ST_DIV : ST_DONE;
					end else if (pos_q < need_pos) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					if (cid_hit) begin
						verdict_q <= V_WORKER;
						target_q  <= rd_tail_q[15:0];
						state_q   <= ST_DONE;
					end else if (32'(scan_q) == 32'(TABLE_ENTRIES - 1)) begin
						state_q <= (long_q && place_ok) ? ST_DIV : ST_DONE;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					rem_q     <= div_try;
					hash_q    <= hash_q << 1;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'd31) begin
						slot_q  <= div_try;
						idx_q   <= '0;
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					if (listen_q[slot_q[5:0]]) begin
						verdict_q <= V_LISTEN;
						target_q  <= 16'(slot_q);
						state_q   <= ST_DONE;
					end else if (idx_q == slot_count_q - 1'b1) begin
						state_q <= ST_DONE;
					end else begin
						idx_q  <= idx_q + 1'b1;
						slot_q <= (slot_q + 1'b1 == slot_count_q) ? '0 : slot_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						pos_q  <= '0;
						long_q <= 1'b0;
						dlm_q  <= 1'b0;
						for (int i = 0; i < MAX_CID; i++) cap_q[i] <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: a verdict may wait here while the next datagram streams in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_verdict_q <= verdict_q;
			out_target_q  <= target_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.verdict = out_verdict_q;
	assign out_ch.target  = out_target_q;

	`QCSS_ASSERT(a_drop_zero, out_ch.valid && out_ch.verdict == V_DROP |-> out_ch.target == '0)
	`QCSS_NEVER(a_bad_verdict, out_ch.valid && out_ch.verdict > V_LISTEN)
	`QCSS_ASSERT(a_rem_range, state_q == ST_DIV |-> rem_q < slot_count_q)
	`QCSS_ASSERT(a_slot_range, state_q == ST_PLACE |-> slot_q < slot_count_q)
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the QUIC connection-ID socket steering unit.
module tb;
	import qcss_pkg::*;

	// One item on the input channel: a datagram byte or a table word write.
	typedef struct {
		logic        kind;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [31:0] flow_hash;
		logic [7:0]  table_index;
		logic [1:0]  table_word_select;
		logic [63:0] table_word;
		logic        table_valid;
		logic [15:0] table_worker;
	} item_t;

	typedef struct {
		logic [1:0]  verdict;
		logic [15:0] target;
	} steer_t;

	// Directed rows: whole table entries, single raw words, or whole datagrams.
	typedef enum {OP_ENTRY, OP_RAW, OP_DGRAM} op_t;

	typedef struct {
		op_t          op;
		int           idx;
		logic [1:0]   sel;
		logic [159:0] cid;
		logic         valid;
		logic [15:0]  worker;
		bit           long_hdr;
		logic [7:0]   len_byte;
		int           total;
		int           cid_from;   // entry whose CID the datagram carries, -1 random
		logic [31:0]  hash;
		bit           typed;      // expectation written in the row
		steer_t       exp;
	} row_t;

	localparam int DRAIN_CYCLES = 700;   // longest decision plus margin
	localparam int HOLD_CYCLES  = 3000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	qcss_in_if  in_bus();
	qcss_out_if out_bus();

	quic_cid_socket_steering_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ---- predictor state ----
	logic [6:0]  slot_count;
	logic [63:0] slot_present;
	int          dg_pos;
	bit          dg_long;
	bit          dg_len_ok;
	logic [7:0]  dg_cid [MAX_CID];
	logic [63:0] tbl_head [DEF_TABLE_ENTRIES];
	logic [63:0] tbl_mid  [DEF_TABLE_ENTRIES];
	logic [31:0] tbl_tail [DEF_TABLE_ENTRIES];
	bit          tbl_valid [DEF_TABLE_ENTRIES];
	logic [15:0] tbl_worker [DEF_TABLE_ENTRIES];
	// stimulus bookkeeping: a valid mark is only ever set on a fully written entry
	bit          head_written [DEF_TABLE_ENTRIES];
	bit          mid_written  [DEF_TABLE_ENTRIES];

	steer_t verdict_q [$];
	int     errors = 0;
	int     items_sent = 0;
	bit     src_idle_en = 1;
	bit     sink_idle_en = 1;
	int     hold_left = 0;
	bit     use_typed = 0;
	steer_t typed_exp;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60000000;
		$display("Simulation FAILED");
		$finish;
	end

	// ---- prediction ----
	function automatic steer_t place_new_conn(logic [31:0] hash);
		steer_t r;
		int first, slot;
		r.verdict = V_DROP;
		r.target = '0;
		if (slot_count == 0 || slot_count > DEF_ROUTE_SLOTS)
			return r;
		first = hash % slot_count;
		for (int i = 0; i < slot_count; i++) begin
			slot = first + i;
			if (slot >= slot_count)
				slot -= slot_count;
			if (slot_present[slot]) begin
				r.verdict = V_LISTEN;
				r.target = 16'(slot);
				return r;
			end
		end
		return r;
	endfunction

	function automatic steer_t steer_decide(logic [31:0] hash);
		steer_t r;
		int start;
		logic [159:0] cap;
		r.verdict = V_DROP;
		r.target = '0;
		start = UDP_HDR_LEN + 1;
		if (dg_pos < start)
			return r;
		if (dg_long) begin
			start += LONG_EXTRA;
			if (dg_pos < start)
				return r;
			if (!dg_len_ok)
				return place_new_conn(hash);
		end
		if (dg_pos < start + DEF_CID_BYTES)
			return r;
		for (int i = 0; i < MAX_CID; i++)
			cap[159 - 8*i -: 8] = dg_cid[i];
		// lowest matching index wins
		for (int e = 0; e < DEF_TABLE_ENTRIES; e++)
			if (tbl_valid[e] && {tbl_head[e], tbl_mid[e], tbl_tail[e]} == cap) begin
				r.verdict = V_WORKER;
				r.target = tbl_worker[e];
				return r;
			end
		if (dg_long)
			return place_new_conn(hash);
		return r;
	endfunction

	task automatic steer_predict(input item_t it);
		int p, start;
		steer_t r;
		if (it.kind == KIND_TABLE) begin
			case (it.table_word_select)
				SEL_HEAD: begin
					tbl_head[it.table_index] = it.table_word;
					head_written[it.table_index] = 1;
				end
				SEL_MIDDLE: begin
					tbl_mid[it.table_index] = it.table_word;
					mid_written[it.table_index] = 1;
				end
				SEL_TAIL: begin
					tbl_tail[it.table_index] = it.table_word[63:32];
					tbl_valid[it.table_index] = it.table_valid;
					tbl_worker[it.table_index] = it.table_worker;
				end
				default: ;   // word select 3 is ignored
			endcase
			return;
		end
		if (dg_pos < POS_LIMIT) begin
			p = dg_pos;
			start = dg_long ? UDP_HDR_LEN + 1 + LONG_EXTRA : UDP_HDR_LEN + 1;
			if (p == UDP_HDR_LEN)
				dg_long = it.data_byte[FORM_BIT];
			if (p == UDP_HDR_LEN + LONG_EXTRA)
				dg_len_ok = (it.data_byte == DEF_CID_BYTES);
			if (p > UDP_HDR_LEN && p >= start && p - start < DEF_CID_BYTES)
				dg_cid[p - start] = it.data_byte;
			dg_pos = p + 1;
		end
		if (!it.last_byte)
			return;
		r = use_typed ? typed_exp : steer_decide(it.flow_hash);
		verdict_q.push_back(r);
		dg_pos = 0;
		dg_long = 0;
		dg_len_ok = 0;
		for (int i = 0; i < MAX_CID; i++)
			dg_cid[i] = '0;
	endtask

	// ---- input side: called at a falling edge, returns at a falling edge ----
	task automatic offer(input item_t it);
		if (src_idle_en)
			while ($urandom_range(99) < 13) begin
				in_bus.valid <= 1'b0;
				@(negedge clk);
			end
		in_bus.valid <= 1'b1;
		in_bus.kind <= it.kind;
		in_bus.data_byte <= it.data_byte;
		in_bus.last_byte <= it.last_byte;
		in_bus.flow_hash <= it.flow_hash;
		in_bus.table_index <= it.table_index;
		in_bus.table_word_select <= it.table_word_select;
		in_bus.table_word <= it.table_word;
		in_bus.table_valid <= it.table_valid;
		in_bus.table_worker <= it.table_worker;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		steer_predict(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic table_raw(input int idx, input logic [1:0] sel, input logic [63:0] word,
			input logic valid, input logic [15:0] worker);
		item_t it;
		it.kind = KIND_TABLE;
		it.data_byte = 8'($urandom);
		it.last_byte = 1'($urandom);
		it.flow_hash = $urandom;
		it.table_index = 8'(idx);
		it.table_word_select = sel;
		it.table_word = word;
		it.table_valid = valid;
		it.table_worker = worker;
		offer(it);
	endtask

	task automatic write_entry(input int idx, input logic [159:0] cid, input logic valid,
			input logic [15:0] worker);
		table_raw(idx, SEL_HEAD, cid[159:96], 1'($urandom), 16'($urandom));
		table_raw(idx, SEL_MIDDLE, cid[95:32], 1'($urandom), 16'($urandom));
		table_raw(idx, SEL_TAIL, {cid[31:0], 32'($urandom)}, valid, worker);
	endtask

	task automatic send_dgram(input bit long_hdr, input logic [7:0] len_byte, input int total,
			input int cid_from, input logic [31:0] hash);
		logic [7:0] bytes [48];
		logic [159:0] cid;
		int start;
		item_t it;
		for (int i = 0; i < 48; i++)
			bytes[i] = 8'($urandom);
		bytes[UDP_HDR_LEN][FORM_BIT] = long_hdr;
		if (long_hdr)
			bytes[UDP_HDR_LEN + LONG_EXTRA] = len_byte;
		if (cid_from >= 0) begin
			cid = {tbl_head[cid_from], tbl_mid[cid_from], tbl_tail[cid_from]};
			start = long_hdr ? UDP_HDR_LEN + 1 + LONG_EXTRA : UDP_HDR_LEN + 1;
			for (int i = 0; i < MAX_CID; i++)
				bytes[start + i] = cid[159 - 8*i -: 8];
		end
		for (int i = 0; i < total; i++) begin
			it.kind = KIND_BYTE;
			it.data_byte = bytes[i];
			it.last_byte = (i == total - 1);
			it.flow_hash = it.last_byte ? hash : 32'($urandom);
			it.table_index = 8'($urandom);
			it.table_word_select = 2'($urandom);
			it.table_word = {32'($urandom), 32'($urandom)};
			it.table_valid = 1'($urandom);
			it.table_worker = 16'($urandom);
			offer(it);
		end
	endtask

	// Settle the block, then write the slot count and presence registers; only ever done while nothing is in flight.
	task automatic set_slots(input logic [6:0] count, input logic [63:0] present);
		in_bus.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SLOT_COUNT;
		cfg_data <= 64'(count);
		@(negedge clk);
		cfg_index <= CFG_SLOT_PRESENT;
		cfg_data <= present;
		@(negedge clk);
		cfg_we <= 1'b0;
		slot_count = count;
		slot_present = present;
	endtask

	function automatic int pick_valid_entry();
		int e;
		for (int t = 0; t < 16; t++) begin
			e = $urandom_range(DEF_TABLE_ENTRIES - 1);
			if (tbl_valid[e])
				return e;
		end
		return -1;
	endfunction

	task automatic random_traffic(input int goal);
		int r, idx, total;
		logic [1:0] sel;
		logic v;
		bit long_hdr;
		logic [7:0] len_byte;
		while (items_sent < goal) begin
			r = $urandom_range(99);
			if (r < 8) begin
				idx = $urandom_range(DEF_TABLE_ENTRIES - 1);
				sel = 2'($urandom);
				v = 1'($urandom);
				// never mark valid an entry whose CID words were not all written
				if (!(head_written[idx] && mid_written[idx]))
					v = 1'b0;
				table_raw(idx, sel, {32'($urandom), 32'($urandom)}, v, 16'($urandom));
			end else if (r < 20) begin
				write_entry($urandom_range(DEF_TABLE_ENTRIES - 1),
					{32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
					32'($urandom)}, $urandom_range(3) != 0, 16'($urandom));
			end else begin
				long_hdr = $urandom_range(99) < 60;
				len_byte = ($urandom_range(3) != 0) ? 8'(DEF_CID_BYTES) : 8'($urandom);
				if ($urandom_range(99) < 85)
					total = long_hdr ? $urandom_range(34, 40) : $urandom_range(29, 40);
				else
					total = $urandom_range(1, 33);
				send_dgram(long_hdr, len_byte, total,
					($urandom_range(1) != 0) ? pick_valid_entry() : -1, $urandom);
			end
		end
	endtask

	// ---- output side: ready at falling edges, results checked at rising edges ----
	initial begin
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_bus.ready <= 1'b0;
				hold_left--;
			end else
				out_bus.ready <= !(sink_idle_en && $urandom_range(99) < 13);
		end
	end

	always @(posedge clk) begin
		steer_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (verdict_q.size() == 0) begin
				$error("verdict with none expected: verdict %0d target %0d",
					out_bus.verdict, out_bus.target);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (out_bus.verdict !== want.verdict) begin
					$error("verdict: expected %0d, actual %0d", want.verdict, out_bus.verdict);
					errors++;
				end
				if (out_bus.target !== want.target) begin
					$error("target: expected %0d, actual %0d", want.target, out_bus.target);
					errors++;
				end
			end
		end
	end

	// ---- main sequence ----
	initial begin
		row_t rows [$];
		row_t rw;
		logic [6:0]  counts [8];
		logic [63:0] presents [8];
		logic [159:0] cid_a;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_bus.valid = 1'b0;
		in_bus.kind = KIND_BYTE;
		in_bus.data_byte = '0;
		in_bus.last_byte = 1'b0;
		in_bus.flow_hash = '0;
		in_bus.table_index = '0;
		in_bus.table_word_select = SEL_HEAD;
		in_bus.table_word = '0;
		in_bus.table_valid = 1'b0;
		in_bus.table_worker = '0;
		slot_count = '0;
		slot_present = '0;
		dg_pos = 0;
		dg_long = 0;
		dg_len_ok = 0;
		for (int i = 0; i < MAX_CID; i++)
			dg_cid[i] = '0;
		for (int e = 0; e < DEF_TABLE_ENTRIES; e++) begin
			tbl_head[e] = '0;
			tbl_mid[e] = '0;
			tbl_tail[e] = '0;
			tbl_valid[e] = 0;
			tbl_worker[e] = '0;
			head_written[e] = 0;
			mid_written[e] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: four slots, only slot 2 listening
		set_slots(7'd4, 64'h4);
		cid_a = 160'h0123456789abcdef_fedcba9876543210_a5c3_3c5a;

		rw = '{op: OP_DGRAM, idx: 0, sel: SEL_HEAD, cid: '0, valid: 0, worker: 0,
			long_hdr: 0, len_byte: 0, total: 1, cid_from: -1, hash: 0, typed: 1,
			exp: '{verdict: V_DROP, target: 0}};
		rows.push_back(rw);                       // one-byte datagram
		rw.total = 9;
		rows.push_back(rw);                       // short header, no room for DCID
		rw.long_hdr = 1; rw.total = 13;
		rows.push_back(rw);                       // long header cut before DCID length
		rw.len_byte = 5; rw.total = 14;
		rw.exp = '{verdict: V_LISTEN, target: 2};
		rows.push_back(rw);                       // other DCID length: straight to placement
		rw.len_byte = 20; rw.total = 33;
		rw.exp = '{verdict: V_DROP, target: 0};
		rows.push_back(rw);                       // DCID one byte short
		rw = '{op: OP_ENTRY, idx: 255, sel: SEL_TAIL, cid: cid_a, valid: 1,
			worker: 16'hffff, long_hdr: 0, len_byte: 0, total: 0, cid_from: -1, hash: 0,
			typed: 0, exp: '{verdict: V_DROP, target: 0}};
		rows.push_back(rw);
		rw.idx = 0; rw.worker = 16'h0001;
		rows.push_back(rw);                       // duplicate CID at a lower index
		rw.idx = 1; rw.cid = '1; rw.worker = 16'h8000;
		rows.push_back(rw);
		rw = '{op: OP_DGRAM, idx: 0, sel: SEL_HEAD, cid: '0, valid: 0, worker: 0,
			long_hdr: 0, len_byte: 0, total: 29, cid_from: 255, hash: '1, typed: 1,
			exp: '{verdict: V_WORKER, target: 16'h0001}};
		rows.push_back(rw);                       // lowest index wins
		rw.long_hdr = 1; rw.len_byte = 20; rw.total = 40; rw.cid_from = 0;
		rows.push_back(rw);                       // overlong long header, hit
		rw.cid_from = 1; rw.total = 34; rw.exp = '{verdict: V_WORKER, target: 16'h8000};
		rows.push_back(rw);                       // all-ones CID
		rw = '{op: OP_RAW, idx: 0, sel: SEL_TAIL, cid: {32'h0, 64'h0, cid_a[31:0], 32'h0},
			valid: 0, worker: 0, long_hdr: 0, len_byte: 0, total: 0, cid_from: -1,
			hash: 0, typed: 0, exp: '{verdict: V_DROP, target: 0}};
		rows.push_back(rw);                       // invalidate entry 0
		rw.idx = 255; rw.sel = 2'd3; rw.cid = '0; rw.worker = 16'h0bad;
		rows.push_back(rw);                       // word select 3 is ignored
		rw = '{op: OP_DGRAM, idx: 0, sel: SEL_HEAD, cid: '0, valid: 0, worker: 0,
			long_hdr: 0, len_byte: 0, total: 29, cid_from: 255, hash: 0, typed: 1,
			exp: '{verdict: V_WORKER, target: 16'hffff}};
		rows.push_back(rw);
		rw.typed = 0; rw.cid_from = -1;
		rows.push_back(rw);                       // short header miss
		rw.long_hdr = 1; rw.len_byte = 20; rw.total = 34; rw.hash = '1;
		rows.push_back(rw);                       // long header miss, scan wraps

		foreach (rows[i]) begin
			case (rows[i].op)
				OP_ENTRY: write_entry(rows[i].idx, rows[i].cid, rows[i].valid, rows[i].worker);
				OP_RAW: table_raw(rows[i].idx, rows[i].sel, rows[i].cid[95:32],
					rows[i].valid, rows[i].worker);
				default: begin
					use_typed = rows[i].typed;
					typed_exp = rows[i].exp;
					send_dgram(rows[i].long_hdr, rows[i].len_byte, rows[i].total,
						rows[i].cid_from, rows[i].hash);
					use_typed = 0;
				end
			endcase
		end

		// random part over several slot settings, extremes included
		counts[0] = 7'd64;  presents[0] = '1;
		counts[1] = 7'd1;   presents[1] = 64'h1;
		counts[2] = 7'd64;  presents[2] = {32'($urandom), 32'($urandom)};
		counts[3] = 7'($urandom_range(1, 64)); presents[3] = {32'($urandom), 32'($urandom)};
		counts[4] = 7'd127; presents[4] = '1;          // out of range: new connections drop
		counts[5] = 7'd0;   presents[5] = {32'($urandom), 32'($urandom)};
		counts[6] = 7'd64;  presents[6] = '0;          // nothing listening
		counts[7] = 7'($urandom_range(1, 64)); presents[7] = 64'h8000_0000_0000_0001;
		for (int ph = 0; ph < 8; ph++) begin
			set_slots(counts[ph], presents[ph]);
			src_idle_en = (ph != 2);
			sink_idle_en = (ph != 2);
			if (ph == 1)
				hold_left = HOLD_CYCLES;   // receiver stalls while bytes keep coming
			random_traffic(items_sent + 170);
		end

		in_bus.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/qcss_pkg.sv
design/qcss_in_if.sv
design/qcss_out_if.sv
design/quic_cid_socket_steering_unit.sv
tb/sv/tb.sv
